>>> hdl/shs_pkg.sv
// Shared types, constants and round functions for the SHA-512 stream hasher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

    localparam int unsigned WordW    = 64;
    localparam int unsigned HashN    = 8;
    localparam int unsigned BufWords = 16;
    localparam int unsigned Rounds   = 80;
    localparam logic [7:0]  PadByte  = 8'h80;
    localparam logic [6:0]  LenPos   = 7'd112;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_PAD, ST_HLOAD, ST_ROUND, ST_HADD, ST_ERD, ST_EREG, ST_ESEND
    } state_t;

    typedef struct packed {
        logic load_shift;  // shift a hash word into the working registers
        logic round_en;    // run one round
        logic w_from_mem;  // take this round's schedule word from the buffer
    } core_ctrl_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] iv_default(input logic [2:0] i);
        unique case (i)
            3'd0: iv_default = 64'h6a09e667f3bcc908;
            3'd1: iv_default = 64'hbb67ae8584caa73b;
            3'd2: iv_default = 64'h3c6ef372fe94f82b;
            3'd3: iv_default = 64'ha54ff53a5f1d36f1;
            3'd4: iv_default = 64'h510e527fade682d1;
            3'd5: iv_default = 64'h9b05688c2b3e6c1f;
            3'd6: iv_default = 64'h1f83d9abfb41bd6b;
            3'd7: iv_default = 64'h5be0cd19137e2179;
            default: iv_default = '0;
        endcase
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] i);
        case (i)
            7'd0:  round_k = 64'h428a2f98d728ae22;  7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;  7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538;  7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b;  7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242;  7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c;  7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f;  7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235;  7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2;  7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5;  7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275;  7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4;  7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab;  7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f;  7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2;  7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f;  7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc;  7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed;  7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de;  7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6;  7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364;  7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791;  7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218;  7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a;  7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8;  7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99;  7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63;  7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373;  7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc;  7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72;  7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28;  7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915;  7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c;  7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e;  7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba;  7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae;  7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84;  7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc;  7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6;  7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec;  7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> hdl/shs_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module shs_ram #(
    parameter int unsigned Width = 64,
    parameter int unsigned Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hdl/shs_core.sv
// Round datapath: working registers a..h and the 16-word schedule window.
// Depends on shs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module shs_core (
    input  wire logic               aclk,
    input  wire shs_pkg::core_ctrl_t ctrl,
    input  wire logic [6:0]         rnd,
    input  wire logic [63:0]        hash_rdata,
    input  wire logic [63:0]        buf_rdata,
    input  wire logic [2:0]         sel,
    output logic      [63:0]        sel_word
);
    logic [63:0] st_reg   [shs_pkg::HashN];
    logic [63:0] wwin_reg [shs_pkg::BufWords];
    logic [63:0] w_cur;
    logic [63:0] t1;
    logic [63:0] t2;

    always_comb begin
        w_cur = ctrl.w_from_mem ? buf_rdata :
                shs_pkg::ssig1(wwin_reg[14]) + wwin_reg[9] +
                shs_pkg::ssig0(wwin_reg[1]) + wwin_reg[0];
        t1 = st_reg[7] + shs_pkg::bsig1(st_reg[4]) +
             ((st_reg[4] & st_reg[5]) ^ (~st_reg[4] & st_reg[6])) +
             shs_pkg::round_k(rnd) + w_cur;
        t2 = shs_pkg::bsig0(st_reg[0]) +
             ((st_reg[0] & st_reg[1]) ^ (st_reg[0] & st_reg[2]) ^ (st_reg[1] & st_reg[2]));
    end

    assign sel_word = st_reg[sel];

    always_ff @(posedge aclk) begin
        if (ctrl.load_shift) begin
            for (int i = 0; i < 7; i++) begin
                st_reg[i] <= st_reg[i+1];
            end
            st_reg[7] <= hash_rdata;
        end else if (ctrl.round_en) begin
            st_reg[7] <= st_reg[6];
            st_reg[6] <= st_reg[5];
            st_reg[5] <= st_reg[4];
            st_reg[4] <= st_reg[3] + t1;
            st_reg[3] <= st_reg[2];
            st_reg[2] <= st_reg[1];
            st_reg[1] <= st_reg[0];
            st_reg[0] <= t1 + t2;
        end
        if (ctrl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                wwin_reg[i] <= wwin_reg[i+1];
            end
            wwin_reg[15] <= w_cur;
        end
    end
endmodule
`default_nettype wire

>>> hdl/sha512_stream_hasher_top.sv
// Top level of the SHA-512 stream hasher: control sequencer, block buffer and hash state RAMs.
// Depends on shs_pkg, shs_ram and shs_core.
// Sequence: byte items are taken in IDLE; a byte that fills the block starts a compression
// (hash loads, 80 rounds on the shared round unit, read-add-write steps on the hash RAM).
// Finalizing writes padding one byte a cycle, runs one or two compressions, then
// emits eight words, each read in ERD and EREG and held in ESEND until the output is ready.
// Reset: synchronous active-low aresetn; afterwards a pass loads the hash RAM
// from the IV registers, held for each register write that lands during it;
// no item is accepted during the pass.
`timescale 1ns / 1ps
`default_nettype none
module sha512_stream_hasher_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_end_of_message,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_digest_word,
    output logic      [2:0]  m_word_index,
    output logic             m_last_word,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    shs_pkg::state_t    state_reg, state_next;
    shs_pkg::core_ctrl_t ctrl;

    logic [3:0]   cnt_reg;
    logic [6:0]   rnd_reg;
    logic [6:0]   fill_reg;
    logic [63:0]  bc_reg;
    logic [63:0]  pack_reg;
    logic [127:0] len_reg;
    logic         msg_end_reg;
    logic         pad_first_reg;
    logic         len_armed_reg;
    logic [2:0]   word_reg;
    logic [63:0]  dig_reg;
    logic [63:0]  iv_reg [shs_pkg::HashN];

    logic         accept;
    logic         byte_we;
    logic [7:0]   byte_val;
    logic         blk_full;
    logic         len_byte;
    logic [6:0]   fill_inc;
    logic         hram_we;
    logic [2:0]   hram_waddr;
    logic [63:0]  hram_wdata;
    logic [2:0]   hram_raddr;
    logic [63:0]  hram_rdata;
    logic [3:0]   bram_raddr;
    logic [63:0]  bram_rdata;
    logic [2:0]   core_sel;
    logic [63:0]  sel_word;
    logic         cfg_hit;

    assign accept   = s_valid && s_ready;
    assign fill_inc = fill_reg + 7'd1;
    assign blk_full = byte_we && (fill_reg == 7'd127);
    assign len_byte = (state_reg == shs_pkg::ST_PAD) && !pad_first_reg && len_armed_reg &&
                      (fill_reg >= shs_pkg::LenPos);
    assign cfg_hit  = cfg_we && !cfg_index[3];

    shs_ram #(.Width(64), .Depth(shs_pkg::HashN)) u_hash_ram (
        .aclk  (aclk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .raddr (hram_raddr),
        .rdata (hram_rdata)
    );

    shs_ram #(.Width(64), .Depth(shs_pkg::BufWords)) u_buf_ram (
        .aclk  (aclk),
        .we    (byte_we && (fill_reg[2:0] == 3'd7)),
        .waddr (fill_reg[6:3]),
        .wdata ({pack_reg[55:0], byte_val}),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    shs_core u_core (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .rnd        (rnd_reg),
        .hash_rdata (hram_rdata),
        .buf_rdata  (bram_rdata),
        .sel        (core_sel),
        .sel_word   (sel_word)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            shs_pkg::ST_INIT: begin
                if (cnt_reg == 4'd7 && !cfg_hit) state_next = shs_pkg::ST_IDLE;
            end
            shs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (blk_full) begin
                        state_next = shs_pkg::ST_HLOAD;
                    end else if (s_end_of_message) begin
                        state_next = shs_pkg::ST_PAD;
                    end
                end
            end
            shs_pkg::ST_PAD:   if (fill_reg == 7'd127) state_next = shs_pkg::ST_HLOAD;
            shs_pkg::ST_HLOAD: if (cnt_reg == 4'd8) state_next = shs_pkg::ST_ROUND;
            shs_pkg::ST_ROUND: if (rnd_reg == 7'(shs_pkg::Rounds - 1)) state_next = shs_pkg::ST_HADD;
            shs_pkg::ST_HADD: begin
                if (cnt_reg == 4'd8) begin
                    priority if (!msg_end_reg) state_next = shs_pkg::ST_IDLE;
                    else if (pad_first_reg)    state_next = shs_pkg::ST_PAD;
                    else if (len_armed_reg)    state_next = shs_pkg::ST_ERD;
                    else                       state_next = shs_pkg::ST_PAD;
                end
            end
            shs_pkg::ST_ERD:   state_next = shs_pkg::ST_EREG;
            shs_pkg::ST_EREG:  state_next = shs_pkg::ST_ESEND;
            shs_pkg::ST_ESEND: begin
                if (m_ready) begin
                    state_next = (word_reg == 3'd7) ? shs_pkg::ST_IDLE : shs_pkg::ST_ERD;
                end
            end
            default: state_next = shs_pkg::ST_INIT;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        byte_we    = 1'b0;
        byte_val   = s_msg_byte;
        hram_we    = 1'b0;
        hram_waddr = cnt_reg[2:0];
        hram_wdata = iv_reg[cnt_reg[2:0]];
        hram_raddr = cnt_reg[2:0];
        bram_raddr = '0;
        core_sel   = cnt_reg[2:0] - 3'd1;
        ctrl       = '0;
        unique case (state_reg)
            shs_pkg::ST_INIT: begin
                hram_we = 1'b1;
                // a register write wins the port; the pass holds and redoes this entry
                if (cfg_hit) begin
                    hram_waddr = cfg_index[2:0];
                    hram_wdata = cfg_data;
                end
            end
            shs_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                byte_we    = s_valid && s_byte_present;
                // a new IV takes effect at once when no message is under way
                hram_we    = cfg_hit && (fill_reg == 7'd0) && (bc_reg == 64'd0);
                hram_waddr = cfg_index[2:0];
                hram_wdata = cfg_data;
            end
            shs_pkg::ST_PAD: begin
                byte_we = 1'b1;
                priority if (pad_first_reg) byte_val = shs_pkg::PadByte;
                else if (len_byte)          byte_val = len_reg[127:120];
                else                        byte_val = 8'h00;
            end
            shs_pkg::ST_HLOAD: begin
                ctrl.load_shift = (cnt_reg != 4'd0);
            end
            shs_pkg::ST_ROUND: begin
                ctrl.round_en   = 1'b1;
                ctrl.w_from_mem = (rnd_reg < 7'd16);
                bram_raddr      = rnd_reg[3:0] + 4'd1;
            end
            shs_pkg::ST_HADD: begin
                hram_we    = (cnt_reg != 4'd0);
                hram_waddr = core_sel;
                hram_wdata = hram_rdata + sel_word;
            end
            shs_pkg::ST_ERD: begin
                hram_raddr = word_reg;
            end
            shs_pkg::ST_EREG: begin
                // reload the IV behind the word being read out
                hram_we    = 1'b1;
                hram_waddr = word_reg;
                hram_wdata = iv_reg[word_reg];
            end
            shs_pkg::ST_ESEND: begin
                m_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_digest_word = dig_reg;
    assign m_word_index  = word_reg;
    assign m_last_word   = (word_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= shs_pkg::ST_INIT;
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            fill_reg      <= '0;
            bc_reg        <= '0;
            msg_end_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            len_armed_reg <= 1'b0;
            word_reg      <= '0;
            for (int i = 0; i < shs_pkg::HashN; i++) begin
                iv_reg[i] <= shs_pkg::iv_default(3'(i));
            end
        end else begin
            state_reg <= state_next;
            if (cfg_hit) begin
                iv_reg[cfg_index[2:0]] <= cfg_data;
            end

            if (state_next != state_reg) begin
                cnt_reg <= '0;
            end else if (state_reg != shs_pkg::ST_INIT || !cfg_hit) begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            rnd_reg <= (state_reg == shs_pkg::ST_ROUND) ? rnd_reg + 7'd1 : 7'd0;

            if (byte_we) begin
                pack_reg <= {pack_reg[55:0], byte_val};
                fill_reg <= fill_inc;
                if (blk_full) begin
                    bc_reg <= bc_reg + 64'd1;
                end
            end

            if (accept && s_end_of_message) begin
                msg_end_reg   <= 1'b1;
                pad_first_reg <= 1'b1;
                len_armed_reg <= 1'b0;
                // bit length after this item's byte, counting the block it may close
                len_reg <= {54'd0, bc_reg + {63'd0, blk_full},
                            (byte_we ? fill_inc : fill_reg), 3'd0};
            end

            if (state_reg == shs_pkg::ST_PAD) begin
                if (pad_first_reg) begin
                    pad_first_reg <= 1'b0;
                    len_armed_reg <= (fill_reg < shs_pkg::LenPos);
                end else if (len_byte) begin
                    len_reg <= {len_reg[119:0], 8'h00};
                end
            end

            if (state_reg == shs_pkg::ST_HADD && cnt_reg == 4'd8 && msg_end_reg &&
                !pad_first_reg) begin
                len_armed_reg <= 1'b1;
            end

            if (state_reg == shs_pkg::ST_EREG) begin
                dig_reg <= hram_rdata;
            end

            if (state_reg == shs_pkg::ST_ESEND && m_ready) begin
                word_reg <= word_reg + 3'd1;
                if (word_reg == 3'd7) begin
                    fill_reg      <= '0;
                    bc_reg        <= '0;
                    msg_end_reg   <= 1'b0;
                    len_armed_reg <= 1'b0;
                end
            end
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a digest word is pending");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_word) |-> (m_word_index == 3'd7))
        else $error("last word flag on wrong index");

    a_eom_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_message) |=> !s_ready)
        else $error("input accepted right after end of message");

    a_word_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=> (m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest words out of order");

endmodule
`default_nettype wire
